// File: rtl/dsdn_pkg.sv
// shared types, constants and helper functions of the date string to day number unit
package dsdn_pkg;

    // geometry of the stream payloads
    localparam int TEXT_LEN_W    = 15;
    localparam int CHAR_W        = 8;
    localparam int NUM_CHARS     = 10;
    localparam int IN_FIELDS_W   = TEXT_LEN_W + NUM_CHARS * CHAR_W;
    localparam int IN_TDATA_W    = 96;
    localparam int DAY_NUM_W     = 23;
    localparam int OUT_TDATA_W   = 24;

    // parsed field widths
    localparam int YEAR_W        = 14;
    localparam int MONTH_W       = 7;
    localparam int DAY_W         = 7;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH   = 4;

    // characters of interest
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

    // minimum text lengths of the two forms
    localparam logic [TEXT_LEN_W-1:0] LEN_HYPHEN  = 15'd10;
    localparam logic [TEXT_LEN_W-1:0] LEN_COMPACT = 15'd8;

    // value of the day count sum at 15 October 1582, so that date gives day number zero
    localparam logic [23:0] LILIAN_BIAS = 24'd578042;

    // status codes
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // one classified date handed from front to back
    typedef struct packed {
        logic               err;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } date_item_t;

    // true for an ascii decimal digit
    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // value of an ascii digit
    function automatic logic [3:0] digit_val(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] diff;
        diff = c - CHAR_ZERO;
        return diff[3:0];
    endfunction

    // days from march 1 to the first of a month, months counted from march
    function automatic logic [8:0] month_offset(input logic [3:0] mp);
        logic [8:0] off;
        case (mp)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// File: rtl/dsdn_front.sv
// front part: accepts date strings, checks the form and extracts year, month and day
module dsdn_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [dsdn_pkg::IN_FIELDS_W-1:0]    in_data,
    output logic                                push,
    input  logic                                queue_full,
    output dsdn_pkg::date_item_t                item
);
    import dsdn_pkg::*;

    logic [TEXT_LEN_W-1:0] text_length;
    logic [CHAR_W-1:0]     ch [NUM_CHARS];
    logic                  hyphen_form;
    logic                  compact_form;
    logic                  digits_ok;
    logic                  form_ok;
    logic [3:0]            mon_hi;
    logic [3:0]            mon_lo;
    logic [3:0]            day_hi;
    logic [3:0]            day_lo;
    logic [YEAR_W-1:0]     year;
    logic [MONTH_W-1:0]    month;
    logic [DAY_W-1:0]      day;
    date_item_t            item_next;
    date_item_t            item_reg;
    logic                  valid_reg;
    logic                  accept;

    // unpack the characters
    assign text_length = in_data[TEXT_LEN_W-1:0];
    always_comb
    begin
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            ch[i] = in_data[TEXT_LEN_W + i*CHAR_W +: CHAR_W];
        end
    end

    // pick the form
    assign hyphen_form  = (text_length >= LEN_HYPHEN) && (ch[4] == CHAR_HYPHEN);
    assign compact_form = !hyphen_form && (text_length >= LEN_COMPACT);

    // digit checks for each form
    always_comb
    begin
        digits_ok = is_digit(ch[0]) && is_digit(ch[1]) && is_digit(ch[2]) && is_digit(ch[3]);
        if (hyphen_form)
        begin
            digits_ok = digits_ok && is_digit(ch[5]) && is_digit(ch[6])
                        && is_digit(ch[8]) && is_digit(ch[9]) && (ch[7] == CHAR_HYPHEN);
        end
        else
        begin
            digits_ok = digits_ok && is_digit(ch[4]) && is_digit(ch[5])
                        && is_digit(ch[6]) && is_digit(ch[7]);
        end
    end
    assign form_ok = (hyphen_form || compact_form) && digits_ok;

    // field values
    assign mon_hi = hyphen_form ? digit_val(ch[5]) : digit_val(ch[4]);
    assign mon_lo = hyphen_form ? digit_val(ch[6]) : digit_val(ch[5]);
    assign day_hi = hyphen_form ? digit_val(ch[8]) : digit_val(ch[6]);
    assign day_lo = hyphen_form ? digit_val(ch[9]) : digit_val(ch[7]);

    assign year  = YEAR_W'(digit_val(ch[0])) * YEAR_W'(1000)
                 + YEAR_W'(digit_val(ch[1])) * YEAR_W'(100)
                 + YEAR_W'(digit_val(ch[2])) * YEAR_W'(10)
                 + YEAR_W'(digit_val(ch[3]));
    assign month = MONTH_W'(mon_hi) * MONTH_W'(10) + MONTH_W'(mon_lo);
    assign day   = DAY_W'(day_hi) * DAY_W'(10) + DAY_W'(day_lo);

    always_comb
    begin
        item_next.err   = !form_ok || (year == '0) || (month == '0) || (day == '0);
        item_next.year  = year;
        item_next.month = month;
        item_next.day   = day;
    end

    // handshake of the holding register
    assign push     = valid_reg && !queue_full;
    assign in_ready = !valid_reg || !queue_full;
    assign accept   = in_valid && in_ready;
    assign item     = item_reg;

    // holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/dsdn_queue.sv
// short queue of classified dates between front and back
module dsdn_queue #(
    parameter int Depth = dsdn_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dsdn_pkg::date_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 out_valid,
    output dsdn_pkg::date_item_t out_item
);
    import dsdn_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    date_item_t          entry_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg;
    logic [PtrW-1:0]     rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic [PtrW-1:0]     wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_next;
    logic [CntW-1:0]     count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == CntW'(Depth));
    assign out_valid = (count_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && out_valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/dsdn_back.sv
// back part: four stage day count pipeline with output register
module dsdn_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  dsdn_pkg::date_item_t                in_item,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [dsdn_pkg::DAY_NUM_W-1:0] day_number,
    output logic                                status
);
    import dsdn_pkg::*;

    logic                  adv;

    // stage 1: month carry into year
    logic [MONTH_W-1:0]    mm;
    logic [12:0]           mm_scaled;
    logic [3:0]            q_next;
    logic [MONTH_W-1:0]    r_full;
    logic                  v1_reg;
    logic                  err1_reg;
    logic [YEAR_W-1:0]     year1_reg;
    logic [3:0]            q1_reg;
    logic [3:0]            r1_reg;
    logic [DAY_W-1:0]      day1_reg;

    // stage 2: march based year and month
    logic [YEAR_W-1:0]     y_full;
    logic                  pre_march;
    logic [YEAR_W-1:0]     yy_next;
    logic [3:0]            mp;
    logic                  v2_reg;
    logic                  err2_reg;
    logic [YEAR_W-1:0]     yy2_reg;
    logic [8:0]            doy2_reg;
    logic [DAY_W-1:0]      day2_reg;

    // stage 3: leap corrections and year days
    logic [25:0]           cent_scaled;
    logic [21:0]           p365_next;
    logic                  v3_reg;
    logic                  err3_reg;
    logic [21:0]           p365_3_reg;
    logic [11:0]           quad3_reg;
    logic [6:0]            cent3_reg;
    logic [8:0]            doy3_reg;
    logic [DAY_W-1:0]      day3_reg;

    // stage 4: final sum into the output register
    logic [23:0]           sum;
    logic                  out_valid_reg;
    logic [DAY_NUM_W-1:0]  day_number_reg;
    logic                  status_reg;

    assign adv = !out_valid_reg || out_ready;
    assign pop = in_valid && adv;

    // stage 1 logic: mm / 12 by reciprocal 43 / 512, exact for mm below 99
    assign mm        = in_item.month - MONTH_W'(1);
    assign mm_scaled = 13'(mm) * 13'd43;
    assign q_next    = mm_scaled[12:9];
    assign r_full    = mm - MONTH_W'(q_next) * MONTH_W'(12);

    // stage 2 logic
    assign y_full    = year1_reg + YEAR_W'(q1_reg);
    assign pre_march = (r1_reg < 4'd2);
    assign yy_next   = pre_march ? y_full - YEAR_W'(1) : y_full;
    assign mp        = pre_march ? r1_reg + 4'd10 : r1_reg - 4'd2;

    // stage 3 logic: yy / 100 by reciprocal 5243 / 2^19, exact below 10008
    assign cent_scaled = 26'(yy2_reg) * 26'd5243;
    assign p365_next   = 22'(yy2_reg) * 22'd365;

    // stage 4 logic
    assign sum = 24'(p365_3_reg) + 24'(quad3_reg) - 24'(cent3_reg) + 24'(cent3_reg[6:2])
               + 24'(doy3_reg) + 24'(day3_reg) - LILIAN_BIAS;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= pop;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            err1_reg   <= in_item.err;
            year1_reg  <= in_item.year;
            q1_reg     <= q_next;
            r1_reg     <= r_full[3:0];
            day1_reg   <= in_item.day;

            err2_reg   <= err1_reg;
            yy2_reg    <= yy_next;
            doy2_reg   <= month_offset(mp);
            day2_reg   <= day1_reg;

            err3_reg   <= err2_reg;
            p365_3_reg <= p365_next;
            quad3_reg  <= yy2_reg[YEAR_W-1:2];
            cent3_reg  <= cent_scaled[25:19];
            doy3_reg   <= doy2_reg;
            day3_reg   <= day2_reg;

            day_number_reg <= err3_reg ? '0 : sum[DAY_NUM_W-1:0];
            status_reg     <= err3_reg ? STATUS_ERROR : STATUS_OK;
        end
    end

    assign out_valid  = out_valid_reg;
    assign day_number = day_number_reg;
    assign status     = status_reg;

endmodule

// File: rtl/date_string_to_day_number_unit.sv
// top level of the date string to day number unit
//
//  channel  | direction | tdata                                   | tuser
//  s_axis   | in        | text_length, char_0 .. char_9 (96 bits) | -
//  m_axis   | out       | day_number (24 bits)                    | status
//
// one item per cycle sustained while m_axis is not stalled; an accepted item passes through
// the input register, the queue, three arithmetic stages and the output register
// the queue decouples the parsing front from the arithmetic back; a stall on m_axis
// freezes the back, and the front keeps accepting until the queue fills
// rst_n clears all valid bits and queue pointers; no payload clearing is needed
module date_string_to_day_number_unit #(
    parameter int QueueDepth = dsdn_pkg::QUEUE_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // text_length[14:0], char_0[22:15] .. char_9[94:87], zero bit 95
    input  logic [dsdn_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // day_number[22:0] signed, zero bit 23
    output logic [dsdn_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status
    output logic                                m_axis_tuser
);
    import dsdn_pkg::*;

    logic                         q_push;
    logic                         q_full;
    logic                         q_valid;
    logic                         q_pop;
    date_item_t                   front_item;
    date_item_t                   q_item;
    logic signed [DAY_NUM_W-1:0]  day_number;

    // front: parse and classify
    dsdn_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata[IN_FIELDS_W-1:0]),
        .push       (q_push),
        .queue_full (q_full),
        .item       (front_item)
    );

    // queue between front and back
    dsdn_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_item  (q_item)
    );

    // back: day count arithmetic
    dsdn_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_item    (q_item),
        .pop        (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .day_number (day_number),
        .status     (m_axis_tuser)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - DAY_NUM_W){1'b0}}, day_number};

    // the front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("push into full queue");

    // an error result carries a zero day count
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_ERROR)) |-> (day_number == '0))
        else $error("error result with nonzero day count");

    // a good result never lies before 0001-01-01
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == STATUS_OK))
        |-> (day_number >= -DAY_NUM_W'(577735)))
        else $error("day count below calendar start");

endmodule

// File: verif/tb_date_string_to_day_number_unit.sv
// self-checking testbench of the date string to day number unit
`timescale 1ns / 1ps

module tb_date_string_to_day_number_unit;
    import dsdn_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 700;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    // one date string item, drain_first holds it back until all results are in
    typedef struct packed {
        logic [NUM_CHARS-1:0][CHAR_W-1:0] chars;
        logic [TEXT_LEN_W-1:0]            text_length;
        bit                               drain_first;
    } date_text_t;

    // one expected conversion result
    typedef struct packed {
        logic [DAY_NUM_W-1:0] day_number;
        logic                 status;
    } day_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // text_length[14:0], char_0[22:15] .. char_9[94:87], zero bit 95
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // day_number[22:0] signed, zero bit 23
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    // status
    logic                   m_axis_tuser;

    date_text_t  pending_dates[$];
    day_result_t expected_days[$];
    int          mismatch_count = 0;
    int          send_gap = 0;
    int          send_steady = 0;
    int          recv_stall = 0;
    int          recv_steady = 0;

    date_string_to_day_number_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // days from 1970-01-01 of a proleptic gregorian date, year >= 1, month 1..12
    function automatic longint days_from_civil(longint year, longint month, longint day);
        longint shifted_year;
        longint cycle;
        longint year_of_cycle;
        longint month_from_march;
        longint day_of_year;
        shifted_year     = (month <= 2) ? year - 1 : year;
        cycle            = shifted_year / 400;
        year_of_cycle    = shifted_year - cycle * 400;
        month_from_march = (month > 2) ? month - 3 : month + 9;
        day_of_year      = (153 * month_from_march + 2) / 5 + day - 1;
        return cycle * 146097 + year_of_cycle * 365 + year_of_cycle / 4
               - year_of_cycle / 100 + day_of_year - 719468;
    endfunction

    // decimal value of a run of characters, zero return on a non-digit
    function automatic bit read_decimal(date_text_t t, int first, int count, output int value);
        int i;
        value = 0;
        for (i = 0; i < count; i++)
        begin
            if (t.chars[first + i] < CHAR_ZERO || t.chars[first + i] > CHAR_NINE)
                return 1'b0;
            value = value * 10 + int'(t.chars[first + i] - CHAR_ZERO);
        end
        return 1'b1;
    endfunction

    // day number counted from 15 October 1582 as day zero, and status of one date string
    function automatic day_result_t predict_day_number(date_text_t t);
        day_result_t r;
        int          year;
        int          month;
        int          day;
        bit          parsed;
        longint      carried_year;
        longint      carried_month;
        longint      days;
        parsed = 1'b0;
        if (t.text_length >= LEN_HYPHEN && t.chars[4] == CHAR_HYPHEN)
            parsed = (t.chars[7] == CHAR_HYPHEN) && read_decimal(t, 0, 4, year)
                     && read_decimal(t, 5, 2, month) && read_decimal(t, 8, 2, day);
        else if (t.text_length >= LEN_COMPACT)
            parsed = read_decimal(t, 0, 4, year) && read_decimal(t, 4, 2, month)
                     && read_decimal(t, 6, 2, day);
        if (parsed && year > 0 && month > 0 && day > 0)
        begin
            // months past december roll into the year, days past month end roll forward
            carried_year  = year + (month - 1) / 12;
            carried_month = (month - 1) % 12 + 1;
            days = days_from_civil(carried_year, carried_month, 1) + day - 1
                   - days_from_civil(1582, 10, 15);
            r.day_number = days[DAY_NUM_W-1:0];
            r.status     = STATUS_OK;
        end
        else
        begin
            r.day_number = '0;
            r.status     = STATUS_ERROR;
        end
        return r;
    endfunction

    // date string of the given fields, characters outside the form random
    function automatic date_text_t make_text(int year, int month, int day, bit hyphen,
                                             int text_len);
        date_text_t t;
        int         i;
        int         month_pos;
        int         day_pos;
        for (i = 0; i < NUM_CHARS; i++)
            t.chars[i] = CHAR_W'($urandom_range(0, 255));
        t.text_length = TEXT_LEN_W'(text_len);
        t.drain_first = 1'b0;
        for (i = 0; i < 4; i++)
            t.chars[i] = CHAR_ZERO + CHAR_W'((year / (10 ** (3 - i))) % 10);
        month_pos = hyphen ? 5 : 4;
        day_pos   = hyphen ? 8 : 6;
        if (hyphen)
        begin
            t.chars[4] = CHAR_HYPHEN;
            t.chars[7] = CHAR_HYPHEN;
        end
        t.chars[month_pos]     = CHAR_ZERO + CHAR_W'(month / 10);
        t.chars[month_pos + 1] = CHAR_ZERO + CHAR_W'(month % 10);
        t.chars[day_pos]       = CHAR_ZERO + CHAR_W'(day / 10);
        t.chars[day_pos + 1]   = CHAR_ZERO + CHAR_W'(day % 10);
        return t;
    endfunction

    // text length of a well-formed string, mostly the exact size
    function automatic int pick_length(bit hyphen);
        int r;
        r = $urandom_range(0, 99);
        if (hyphen)
            return (r < 85) ? 10 : $urandom_range(11, 32767);
        if (r < 70)
            return 8;
        return (r < 85) ? 9 : $urandom_range(10, 32767);
    endfunction

    // random date string, mostly well-formed, some broken or pure noise
    function automatic date_text_t random_text();
        date_text_t t;
        int         r;
        int         year;
        int         month;
        int         day;
        bit         hyphen;
        int         i;
        r      = $urandom_range(0, 99);
        hyphen = 1'($urandom_range(0, 1));
        year   = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 9999)
                                               : $urandom_range(1, 9999);
        month  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 12) : $urandom_range(0, 99);
        day    = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 31) : $urandom_range(0, 99);
        t = make_text(year, month, day, hyphen, pick_length(hyphen));
        if (r >= 93)
        begin
            // noise
            for (i = 0; i < NUM_CHARS; i++)
                t.chars[i] = CHAR_W'($urandom_range(0, 255));
            t.text_length = TEXT_LEN_W'($urandom_range(0, 32767));
        end
        else if (r >= 85)
        begin
            // one character spoiled, sometimes a short length as well
            t.chars[$urandom_range(0, NUM_CHARS - 1)] = CHAR_W'($urandom_range(0, 255));
            if ($urandom_range(0, 3) == 0)
                t.text_length = TEXT_LEN_W'($urandom_range(0, 9));
        end
        return t;
    endfunction

    // length of an idle stretch, mostly short and a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        return (r < 92) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    endfunction

    // record one mismatch, report the first few
    task automatic note_mismatch(string what, day_result_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch (%s): expected day_number %0d status %0b, got tdata %h status %0b",
                     what, $signed(want.day_number), want.status, m_axis_tdata, m_axis_tuser);
    endtask

    // driver: sends pending items, predicts each one on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_days.push_back(predict_day_number(date_text_t'({s_axis_tdata[94:0], 1'b0})));
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_dates.size() == 0 ||
                         (pending_dates[0].drain_first && expected_days.size() != 0))
                begin
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tdata  <= {1'b0, pending_dates[0].chars, pending_dates[0].text_length};
                    s_axis_tvalid <= 1'b1;
                    void'(pending_dates.pop_front());
                    if (send_steady > 0)
                        send_steady--;
                    else if ($urandom_range(0, 49) == 0)
                        send_steady = $urandom_range(20, 60);
                    send_gap = (send_steady > 0) ? 0 : pick_gap();
                end
            end
        end
    end

    // monitor: checks each result item against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_days.size() == 0)
                    note_mismatch("unexpected item", day_result_t'('0));
                else if (m_axis_tdata !== {1'b0, expected_days[0].day_number} ||
                         m_axis_tuser !== expected_days[0].status)
                    note_mismatch("wrong field", expected_days.pop_front());
                else
                    void'(expected_days.pop_front());
            end
            // backpressure
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end
            else if (recv_steady > 0)
            begin
                recv_steady--;
                m_axis_tready <= 1'b1;
            end
            else if ($urandom_range(0, 99) == 0)
            begin
                recv_steady = $urandom_range(30, 100);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                recv_stall = ($urandom_range(0, 99) < 70) ? 0 : pick_gap();
                m_axis_tready <= (recv_stall == 0);
            end
        end
    end

    // run limit
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // stimulus, reset and end of run
    initial
    begin
        date_text_t t;
        int         i;
        // calendar corners
        pending_dates.push_back(make_text(1582, 10, 15, 1'b1, 10));
        pending_dates.push_back(make_text(1582, 10, 14, 1'b1, 10));
        pending_dates.push_back(make_text(1, 1, 1, 1'b1, 10));
        pending_dates.push_back(make_text(9999, 99, 99, 1'b1, 10));
        pending_dates.push_back(make_text(2024, 2, 29, 1'b0, 8));
        pending_dates.push_back(make_text(1900, 2, 29, 1'b0, 8));
        pending_dates.push_back(make_text(2000, 2, 29, 1'b1, 10));
        pending_dates.push_back(make_text(1600, 2, 29, 1'b1, 10));
        pending_dates.push_back(make_text(2100, 3, 1, 1'b0, 9));
        pending_dates.push_back(make_text(2023, 13, 1, 1'b1, 10));
        pending_dates.push_back(make_text(9999, 99, 99, 1'b0, 8));
        // zero fields
        pending_dates.push_back(make_text(2023, 5, 0, 1'b1, 10));
        pending_dates.push_back(make_text(2023, 0, 5, 1'b0, 8));
        pending_dates.push_back(make_text(0, 5, 5, 1'b1, 10));
        // lengths: empty, one short, widest, hyphen at char 4 with compact length, compact form with length 10
        pending_dates.push_back(make_text(2020, 6, 15, 1'b1, 0));
        pending_dates.push_back(make_text(2020, 6, 15, 1'b0, 7));
        pending_dates.push_back(make_text(2020, 6, 15, 1'b1, 32767));
        pending_dates.push_back(make_text(2020, 6, 15, 1'b1, 9));
        pending_dates.push_back(make_text(1999, 12, 31, 1'b0, 10));
        // non-digits and a bad second hyphen
        t = make_text(2020, 6, 15, 1'b1, 10);
        t.chars[7] = 8'h2F;
        pending_dates.push_back(t);
        t = make_text(2020, 6, 15, 1'b0, 8);
        t.chars[0] = 8'hFF;
        pending_dates.push_back(t);
        t = make_text(2020, 6, 15, 1'b0, 8);
        t.chars[7] = 8'h3A;
        t.chars[4] = 8'h2F;
        pending_dates.push_back(t);
        t = make_text(2020, 6, 15, 1'b1, 10);
        t.chars = '0;
        pending_dates.push_back(t);
        t = make_text(2020, 6, 15, 1'b0, 8);
        t.chars = '1;
        pending_dates.push_back(t);
        // random part, a full drain before it and once in the middle
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            t = random_text();
            t.drain_first = (i == 0) || (i == RANDOM_ITEMS / 2);
            pending_dates.push_back(t);
        end

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_dates.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_days.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: date_string_to_day_number_unit.f
rtl/dsdn_pkg.sv
rtl/dsdn_front.sv
rtl/dsdn_queue.sv
rtl/dsdn_back.sv
rtl/date_string_to_day_number_unit.sv
verif/tb_date_string_to_day_number_unit.sv
